// File: hdl/lot_pkg.sv
// Shared types and constants of the LRU order tracker.
package lot_pkg;

	// Width of a key word on the ports.
	localparam int KEY_W = 32;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;    // take the input word and clear the search results
		logic scan;     // read one slot for the key search
		logic update;   // read one slot for the rank rewrite
		logic publish;  // load the result register and commit the count
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;     // the slot index is at the final slot
		logic out_hold; // the result register still holds an untaken word
	} sts_t;

endpackage

// File: hdl/lru_order_tracker.sv
// LRU order tracker: recency order over up to CAPACITY distinct keys.
// Each word is a touch (mode 0: move the key to the most recent place, or
// insert it there) or a delete (mode 1), and gives one result word with the
// status, the number of keys held and the most and least recent keys (zero
// when nothing is held). A new key is rejected with status full when all
// CAPACITY slots are taken; eviction is left to the user. Keys are compared
// on their low KEY_BITS bits. A new word is taken only after the last one is
// published: the single read port of the slot memory is swept once to search
// the key and once to rewrite the ranks. A finished result waits in an output
// register while the next word is taken. Valid bits are cleared by reset, so
// no clearing pass is needed.
module lru_order_tracker #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      mode,
	input  logic [lot_pkg::KEY_W-1:0] key,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [4:0]                count,
	output logic [lot_pkg::KEY_W-1:0] front_key,
	output logic [lot_pkg::KEY_W-1:0] back_key
);
	import lot_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	lot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage, search and result register.
	lot_datapath #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.mode      (mode),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.count     (count),
		.front_key (front_key),
		.back_key  (back_key)
	);

endmodule

// File: hdl/lot_ctrl.sv
// Controller state machine that sequences the search and rewrite sweeps.
module lot_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lot_pkg::sts_t sts,
	output lot_pkg::cmd_t cmd
);
	import lot_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_UPDATE,
		S_UPD_END,
		S_PUBLISH
	} state_t;

	state_t state_q;

	// Commands follow directly from the state.
	always_comb begin
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			S_SCAN:    cmd.scan    = 1'b1;
			S_UPDATE:  cmd.update  = 1'b1;
			S_PUBLISH: cmd.publish = !sts.out_hold;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.last) state_q <= S_SCAN_END;
				end
				S_SCAN_END: state_q <= S_UPDATE;
				S_UPDATE: begin
					if (sts.last) state_q <= S_UPD_END;
				end
				S_UPD_END: state_q <= S_PUBLISH;
				S_PUBLISH: begin
					if (!sts.out_hold) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/lot_datapath.sv
// Datapath of the LRU order tracker: slot memory, valid bits, search and rank rewrite.
module lot_datapath #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lot_pkg::cmd_t              cmd,
	output lot_pkg::sts_t              sts,
	input  logic                       mode,
	input  logic [lot_pkg::KEY_W-1:0]  key,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic [4:0]                 count,
	output logic [lot_pkg::KEY_W-1:0]  front_key,
	output logic [lot_pkg::KEY_W-1:0]  back_key
);
	import lot_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int MW = SW + IW;
	localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

	// Slot memory: key in the upper bits, rank in the lower bits.
	logic [MW-1:0]       slot_mem_q [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [CW-1:0]       count_q;

	logic [IW-1:0] idx_q;
	logic          rd_s1;
	logic          upd_s1;
	logic [IW-1:0] addr_s1;
	logic [MW-1:0] rdata_s1;

	logic          mode_q;
	logic [SW-1:0] key_q;
	logic          hit_found_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] hit_rank_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;
	logic [SW-1:0] front_q;
	logic [SW-1:0] back_q;

	logic          out_valid_q;
	status_t       out_status_q;
	logic [4:0]    out_count_q;
	logic [KEY_W-1:0] out_front_q;
	logic [KEY_W-1:0] out_back_q;

	logic [SW-1:0] key_rd;
	logic [IW-1:0] rank_rd;
	logic          valid_rd;
	logic          op_touch_hit;
	logic          op_insert;
	logic          op_full;
	logic          op_del;
	logic          op_miss;
	logic [CW-1:0] new_count;
	logic [CW-1:0] back_rank;
	status_t       status_c;
	logic          is_hit_slot;
	logic          is_free_slot;
	logic [IW-1:0] new_rank;
	logic          post_valid;
	logic [SW-1:0] post_key;
	logic [IW-1:0] post_rank;

	assign key_rd   = rdata_s1[MW-1:IW];
	assign rank_rd  = rdata_s1[IW-1:0];
	assign valid_rd = valid_q[addr_s1];

	assign sts.last     = (idx_q == LAST_IDX);
	assign sts.out_hold = out_valid_q && !out_ready;

	// Decide the operation from the search results.
	always_comb begin
		op_touch_hit = !mode_q && hit_found_q;
		op_insert    = !mode_q && !hit_found_q && (count_q < FULL_CNT) && free_found_q;
		op_full      = !mode_q && !hit_found_q && !(count_q < FULL_CNT);
		op_del       = mode_q && hit_found_q;
		op_miss      = mode_q && !hit_found_q;
		if (op_insert) begin
			new_count = CW'(count_q + 1'b1);
		end else if (op_del) begin
			new_count = CW'(count_q - 1'b1);
		end else begin
			new_count = count_q;
		end
		back_rank = CW'(new_count - 1'b1);
		if (op_full) begin
			status_c = ST_FULL;
		end else if (op_miss) begin
			status_c = ST_MISS;
		end else begin
			status_c = ST_DONE;
		end
	end

	// New contents of the slot that the rewrite sweep is visiting.
	always_comb begin
		is_hit_slot  = hit_found_q && (addr_s1 == hit_idx_q);
		is_free_slot = op_insert && (addr_s1 == free_idx_q);
		new_rank     = rank_rd;
		if (op_touch_hit) begin
			if (is_hit_slot) begin
				new_rank = '0;
			end else if (valid_rd && (rank_rd < hit_rank_q)) begin
				new_rank = IW'(rank_rd + 1'b1);
			end
		end else if (op_insert) begin
			if (valid_rd) new_rank = IW'(rank_rd + 1'b1);
		end else if (op_del) begin
			if (valid_rd && (rank_rd > hit_rank_q)) new_rank = IW'(rank_rd - 1'b1);
		end
		if (is_free_slot) begin
			post_valid = 1'b1;
			post_key   = key_q;
			post_rank  = '0;
		end else begin
			post_valid = valid_rd && !(op_del && is_hit_slot);
			post_key   = key_rd;
			post_rank  = new_rank;
		end
	end

	// Control registers: sweep index, read pipeline, flags, valid bits, count, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			rd_s1        <= 1'b0;
			upd_s1       <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			valid_q      <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_s1  <= cmd.scan || cmd.update;
			upd_s1 <= cmd.update;
			if (cmd.start) begin
				idx_q <= '0;
			end else if (cmd.scan || cmd.update) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : IW'(idx_q + 1'b1);
			end
			if (cmd.start) begin
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else if (rd_s1 && !upd_s1) begin
				if (valid_rd && (key_rd == key_q)) hit_found_q <= 1'b1;
				if (!valid_rd) free_found_q <= 1'b1;
			end
			if (rd_s1 && upd_s1) valid_q[addr_s1] <= post_valid;
			if (cmd.publish) begin
				count_q     <= new_count;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the search and the sweep.
	always_ff @(posedge clk) begin
		if (cmd.scan || cmd.update) begin
			rdata_s1 <= slot_mem_q[idx_q];
			addr_s1  <= idx_q;
		end
		if (cmd.start) begin
			mode_q  <= mode;
			key_q   <= SW'(key);
			front_q <= '0;
			back_q  <= '0;
		end else if (rd_s1 && !upd_s1) begin
			if (valid_rd && (key_rd == key_q) && !hit_found_q) begin
				hit_idx_q  <= addr_s1;
				hit_rank_q <= rank_rd;
			end
			if (!valid_rd && !free_found_q) free_idx_q <= addr_s1;
		end else if (rd_s1 && upd_s1) begin
			if (post_valid && (post_rank == '0)) front_q <= post_key;
			if (post_valid && (CW'(post_rank) == back_rank)) back_q <= post_key;
		end
	end

	// Slot memory write port.
	always_ff @(posedge clk) begin
		if (rd_s1 && upd_s1 && post_valid) slot_mem_q[addr_s1] <= {post_key, post_rank};
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_status_q <= status_c;
			out_count_q  <= 5'(new_count);
			out_front_q  <= KEY_W'(front_q);
			out_back_q   <= KEY_W'(back_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign count     = out_count_q;
	assign front_key = out_front_q;
	assign back_key  = out_back_q;

endmodule

// File: hdl/lot_checker.sv
// Port checker for the LRU order tracker and its bind to the top level.
module lot_checker #(
	parameter int CAPACITY = 16
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [1:0]                status,
	input logic [4:0]                count,
	input logic [lot_pkg::KEY_W-1:0] front_key,
	input logic [lot_pkg::KEY_W-1:0] back_key
);
	import lot_pkg::*;

	// A rejected insert only happens with every slot taken.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> count == 5'(CAPACITY))
		else $error("full status with a count below capacity");

	// An empty store reports zero keys.
	a_empty_keys: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (count == 5'd0) && (CAPACITY < 32) |-> (front_key == '0) && (back_key == '0))
		else $error("nonzero key reported for an empty store");

	// With a single key held, it is both the most and least recent.
	a_single_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (count == 5'd1) && (CAPACITY < 32) |-> front_key == back_key)
		else $error("front and back keys differ with one key held");

	// A result word that is not taken holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count)
			&& $stable(front_key) && $stable(back_key))
		else $error("result word changed before it was taken");

	// Once a word is taken, the input closes while the sweeps run.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input open right after a word was taken");

endmodule

bind lru_order_tracker lot_checker #(.CAPACITY(CAPACITY)) u_lot_checker (.*);
